// ===== rtl/sbf_pkg.sv =====
// sbf_pkg: shared types and codes for the store buffer with load forwarding
// word layouts for the input and result channels, cell entry and command types
// no dependencies
`default_nettype none

package sbf_pkg;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_RETIRE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // status codes of a result word
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned ValueW = 32;

  // forward value returned on a miss
  localparam logic signed [ValueW-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic [1:0]               mode;
    logic [AddrW-1:0]         store_address;
    logic signed [ValueW-1:0] store_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     hit;
    logic signed [ValueW-1:0] forward_value;
    logic                     mem_write_enable;
    logic [AddrW-1:0]         mem_write_address;
    logic signed [ValueW-1:0] mem_write_data;
  } out_word_t;

  // contents of one buffer cell
  typedef struct packed {
    logic                     valid;
    logic [AddrW-1:0]         addr;
    logic signed [ValueW-1:0] value;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                     push;
    logic                     retire;
    logic [AddrW-1:0]         addr;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sbf_cell.sv =====
// sbf_cell: one slot of the store buffer, holds a single address/value entry
// compares against the broadcast address and shifts in its younger neighbor on retire
// depends on sbf_pkg
`default_nettype none

module sbf_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire sbf_pkg::cell_cmd_t cmd,
  input  wire                     older_hit_i,
  input  wire                     prev_valid_i,
  input  wire sbf_pkg::entry_t    nbr_i,
  output sbf_pkg::entry_t         ent_o,
  output logic                    hit_chain_o,
  output logic                    sel_o
);

  logic                             valid_r, valid_nxt;
  logic [sbf_pkg::AddrW-1:0]        addr_r, addr_nxt;
  logic signed [sbf_pkg::ValueW-1:0] value_r, value_nxt;
  logic                             match;

  // address compare and oldest-match chain
  assign match       = valid_r && (addr_r == cmd.addr);
  assign hit_chain_o = older_hit_i | match;
  assign sel_o       = match & ~older_hit_i;

  assign ent_o.valid = valid_r;
  assign ent_o.addr  = addr_r;
  assign ent_o.value = value_r;

  // next entry: close the gap on retire, fill the tail slot on push
  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    value_nxt = value_r;
    if (cmd.retire && (older_hit_i || match)) begin
      valid_nxt = nbr_i.valid;
      addr_nxt  = nbr_i.addr;
      value_nxt = nbr_i.value;
    end else if (cmd.push && !valid_r && prev_valid_i) begin
      valid_nxt = 1'b1;
      addr_nxt  = cmd.addr;
      value_nxt = cmd.value;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/store_buffer_forwarding_top.sv =====
// store_buffer_forwarding_top: ordered store buffer with write back and load forwarding
//
//   channel  ports                      handshake
//   input    in_word                    taken when start && !busy
//   result   out_word                   one cycle, marked by out_valid
//
// one word enters per cycle; busy stays low
// a word is registered, resolved against the cell row the next cycle,
// and its result word is strobed in the cycle after that
// the cell row compares all entries at once; a retire shifts younger entries down
// synchronous active-low reset empties the buffer; entry payloads are not cleared
// the receiver cannot stall, so the result register is overwritten every cycle
// depends on sbf_pkg, sbf_cell
`default_nettype none

module store_buffer_forwarding_top #(
  parameter int BUFFER_DEPTH = 16,
  parameter int ADDRESS_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire sbf_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output sbf_pkg::out_word_t      out_word
);

  localparam int KeyBits = (ADDRESS_BITS < 16) ? ADDRESS_BITS : 16;
  localparam logic [sbf_pkg::AddrW-1:0] AddrMask =
    sbf_pkg::AddrW'((64'd1 << KeyBits) - 64'd1);

  logic                 cmd_vld_r;
  sbf_pkg::in_word_t    cmd_r;
  logic                 out_valid_r;
  sbf_pkg::out_word_t   out_word_r, out_word_nxt;

  sbf_pkg::cell_cmd_t   cell_cmd;
  sbf_pkg::entry_t      ent   [BUFFER_DEPTH];
  sbf_pkg::entry_t      nbr   [BUFFER_DEPTH];
  logic [BUFFER_DEPTH:0] chain;
  logic [BUFFER_DEPTH-1:0] sel;
  logic [BUFFER_DEPTH-1:0] prev_valid;
  logic signed [sbf_pkg::ValueW-1:0] sel_value;
  logic [sbf_pkg::AddrW-1:0] key;
  logic                 any_hit, full;

  assign busy = 1'b0;

  // command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= in_word;
  end

  assign key     = cmd_r.store_address & AddrMask;
  assign any_hit = chain[BUFFER_DEPTH];
  assign full    = ent[BUFFER_DEPTH-1].valid;

  // broadcast command to the cells
  always_comb begin
    cell_cmd.push   = cmd_vld_r && (cmd_r.mode == sbf_pkg::MODE_ADD) && !full;
    cell_cmd.retire = cmd_vld_r && (cmd_r.mode == sbf_pkg::MODE_RETIRE) && any_hit;
    cell_cmd.addr   = key;
    cell_cmd.value  = cmd_r.store_value;
  end

  assign chain[0]      = 1'b0;
  assign prev_valid[0] = 1'b1;

  // row of cells, oldest entry in cell 0
  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    if (i == BUFFER_DEPTH - 1) begin : g_last
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i]          = ent[i+1];
      assign prev_valid[i+1] = ent[i].valid;
    end

    sbf_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cell_cmd),
      .older_hit_i  (chain[i]),
      .prev_valid_i (prev_valid[i]),
      .nbr_i        (nbr[i]),
      .ent_o        (ent[i]),
      .hit_chain_o  (chain[i+1]),
      .sel_o        (sel[i])
    );
  end

  // value of the oldest match, one-hot select
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      if (sel[i]) begin
        sel_value = sel_value | ent[i].value;
      end
    end
  end

  // result word
  always_comb begin
    out_word_nxt.status            = sbf_pkg::STATUS_OK;
    out_word_nxt.hit               = 1'b0;
    out_word_nxt.forward_value     = sbf_pkg::MISS_VALUE;
    out_word_nxt.mem_write_enable  = 1'b0;
    out_word_nxt.mem_write_address = '0;
    out_word_nxt.mem_write_data    = '0;
    case (cmd_r.mode)
      sbf_pkg::MODE_ADD: begin
        if (full) begin
          out_word_nxt.status = sbf_pkg::STATUS_FULL;
        end
      end
      sbf_pkg::MODE_RETIRE: begin
        if (any_hit) begin
          out_word_nxt.hit               = 1'b1;
          out_word_nxt.mem_write_enable  = 1'b1;
          out_word_nxt.mem_write_address = key;
          out_word_nxt.mem_write_data    = sel_value;
        end else begin
          out_word_nxt.status = sbf_pkg::STATUS_ABSENT;
        end
      end
      sbf_pkg::MODE_LOOKUP: begin
        if (any_hit) begin
          out_word_nxt.hit           = 1'b1;
          out_word_nxt.forward_value = sel_value;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
